>>> hw/rtl/hfl_pkg.sv
// Package for the handle table free list: defaults, codes and control types.
`default_nettype none

package hfl_pkg;

  localparam int CAPACITY_DEF     = 256;
  localparam int GROW_STEP_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MAP   = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_BAD_HANDLE   = 2'd2,
    ST_NULL_PAYLOAD = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic take;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/hfl_ctrl.sv
// Controller state machine: accepts a transaction, then sequences its execute cycle.
`default_nettype none

module hfl_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  hfl_pkg::dp_status_t dp_status,
  output hfl_pkg::ctrl_cmd_t  ctrl_cmd
);

  hfl_pkg::state_t state;
  hfl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hfl_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = hfl_pkg::S_EXEC;
        end
      end
      hfl_pkg::S_EXEC: begin
        if (!dp_status.out_busy) begin
          state_next = hfl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hfl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl_cmd.take = 1'b0;
    ctrl_cmd.exec = 1'b0;
    case (state)
      hfl_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        ctrl_cmd.take = in_valid;
      end
      hfl_pkg::S_EXEC: begin
        ctrl_cmd.exec = !dp_status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/hfl_dpath.sv
// Datapath: entry memory, free-list registers, command evaluation and output register.
`default_nettype none

module hfl_dpath #(
  parameter int CAPACITY     = hfl_pkg::CAPACITY_DEF,
  parameter int GROW_STEP    = hfl_pkg::GROW_STEP_DEF,
  parameter int PAYLOAD_BITS = hfl_pkg::PAYLOAD_BITS_DEF,
  localparam int HANDLE_W    = $clog2(CAPACITY + 1)
) (
  input  wire                       clk,
  input  wire                       rst,
  input  hfl_pkg::ctrl_cmd_t        ctrl_cmd,
  output hfl_pkg::dp_status_t       dp_status,
  input  hfl_pkg::cmd_t             cmd_in,
  input  wire [HANDLE_W-1:0]        handle_in,
  input  wire [PAYLOAD_BITS-1:0]    payload_in,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [HANDLE_W-1:0]       handle_out,
  output logic [PAYLOAD_BITS-1:0]   payload_out,
  output hfl_pkg::status_t          status,
  output logic [HANDLE_W-1:0]       in_use_count
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int DATA_W  = (PAYLOAD_BITS > HANDLE_W) ? PAYLOAD_BITS : HANDLE_W;
  localparam int ENTRY_W = DATA_W + 1;

  // entry word: {valid, payload or next-free link}
  logic [ENTRY_W-1:0] mem [CAPACITY];

  // entries at or above fresh_ptr are still in their grow-time link order
  logic [HANDLE_W-1:0]     free_head;
  logic [HANDLE_W-1:0]     active_size;
  logic [HANDLE_W-1:0]     fresh_ptr;
  logic [HANDLE_W-1:0]     used_count;
  hfl_pkg::cmd_t           cmd_q;
  logic [HANDLE_W-1:0]     handle_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [ENTRY_W-1:0]      rd_word;

  logic [HANDLE_W-1:0]     free_head_next;
  logic [HANDLE_W-1:0]     active_size_next;
  logic [HANDLE_W-1:0]     fresh_ptr_next;
  logic [HANDLE_W-1:0]     used_count_next;
  logic [HANDLE_W-1:0]     handle_res;
  logic [PAYLOAD_BITS-1:0] payload_res;
  hfl_pkg::status_t        status_res;

  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [ENTRY_W-1:0]      wr_data;

  logic                    grow_due;
  logic                    grow_fits;
  logic [HANDLE_W-1:0]     active_grown;
  logic [HANDLE_W-1:0]     handle_idx;
  logic [HANDLE_W-1:0]     next_link;
  logic                    hit;

  assign handle_idx   = handle_q - HANDLE_W'(1);
  assign grow_due     = (free_head == active_size);
  assign grow_fits    = ({1'b0, active_size} + (HANDLE_W + 1)'(GROW_STEP))
                        <= (HANDLE_W + 1)'(CAPACITY);
  assign active_grown = active_size + HANDLE_W'(GROW_STEP);
  assign hit          = (handle_q != '0) && (handle_q <= active_size)
                        && (handle_q <= fresh_ptr) && rd_word[DATA_W];

  always_comb begin
    if (cmd_in == hfl_pkg::CMD_ALLOC) begin
      rd_addr = free_head[IDX_W-1:0];
    end else begin
      rd_addr = IDX_W'(handle_in - HANDLE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.take) begin
      rd_word   <= mem[rd_addr];
      cmd_q     <= cmd_in;
      handle_q  <= handle_in;
      payload_q <= payload_in;
    end
    if (ctrl_cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    free_head_next   = free_head;
    active_size_next = active_size;
    fresh_ptr_next   = fresh_ptr;
    used_count_next  = used_count;
    handle_res       = '0;
    payload_res      = '0;
    status_res       = hfl_pkg::ST_OK;
    wr_en            = 1'b0;
    wr_addr          = free_head[IDX_W-1:0];
    wr_data          = {1'b1, DATA_W'(payload_q)};
    next_link        = rd_word[HANDLE_W-1:0];
    case (cmd_q)
      hfl_pkg::CMD_ALLOC: begin
        if (grow_due && !grow_fits) begin
          status_res = hfl_pkg::ST_FULL;
        end else begin
          if (grow_due) begin
            active_size_next = active_grown;
          end
          if (payload_q == '0) begin
            status_res = hfl_pkg::ST_NULL_PAYLOAD;
          end else if (free_head < active_size_next) begin
            wr_en           = 1'b1;
            used_count_next = used_count + HANDLE_W'(1);
            handle_res      = free_head + HANDLE_W'(1);
            if (free_head == fresh_ptr) begin
              fresh_ptr_next = fresh_ptr + HANDLE_W'(1);
              next_link      = fresh_ptr + HANDLE_W'(1);
            end
            if (next_link > active_size_next) begin
              free_head_next = active_size_next;
            end else begin
              free_head_next = next_link;
            end
          end else begin
            status_res = hfl_pkg::ST_FULL;
          end
        end
      end
      hfl_pkg::CMD_MAP, hfl_pkg::CMD_FREE: begin
        if (!hit) begin
          status_res = hfl_pkg::ST_BAD_HANDLE;
        end else begin
          payload_res = rd_word[PAYLOAD_BITS-1:0];
          if (cmd_q == hfl_pkg::CMD_FREE) begin
            wr_en          = 1'b1;
            wr_addr        = handle_idx[IDX_W-1:0];
            wr_data        = {1'b0, DATA_W'(free_head)};
            free_head_next = handle_idx;
            if (used_count != '0) begin
              used_count_next = used_count - HANDLE_W'(1);
            end
          end
        end
      end
      default: begin
        status_res = hfl_pkg::ST_BAD_HANDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      active_size <= '0;
      fresh_ptr   <= '0;
      used_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl_cmd.exec) begin
        free_head   <= free_head_next;
        active_size <= active_size_next;
        fresh_ptr   <= fresh_ptr_next;
        used_count  <= used_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec) begin
      handle_out   <= handle_res;
      payload_out  <= payload_res;
      status       <= status_res;
      in_use_count <= used_count_next;
    end
  end

  assign dp_status.out_busy = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_fresh_in_range: assert property (@(posedge clk) disable iff (rst)
    fresh_ptr <= active_size)
    else $error("fresh pointer above active size");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= active_size)
    else $error("free head above active size");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_count <= fresh_ptr)
    else $error("used count exceeds allocated entries");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.exec |=> out_valid)
    else $error("executed transaction produced no result");

  a_exec_not_blocked: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.exec |-> !dp_status.out_busy)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/handle_table_free_list.sv
// Handle table with an embedded free list: top level joining controller and datapath.
//
// Slave stream takes one command per transaction: s_axis_tuser carries the command
// (allocate, map, free), s_axis_tdata the handle and payload. Master stream returns
// exactly one result per command: m_axis_tuser carries the status, m_axis_tdata the
// handle, payload and in-use count after the command.
// Each command passes an accept cycle and an execute state: the accept cycle issues the
// single read of the entry memory, and the execute state uses that registered read (the
// free-list head depends on it), writes back at most one entry and loads the output
// register. A new command is accepted only after the previous one has left execute;
// each result is presented on the master side from the output register.
// Growth of the table by GROW_STEP entries is a register update only; entries not
// yet handed out are linked in index order implicitly.
// Reset clears the free-list head, active size and use count; the table is empty and
// accepts commands as soon as reset is released, with no memory clearing pass.
// If the receiver stalls, the pending result holds in the output register; one more
// command may be accepted, and it waits in execute until the register frees.
`default_nettype none

module handle_table_free_list #(
  parameter int CAPACITY     = hfl_pkg::CAPACITY_DEF,
  parameter int GROW_STEP    = hfl_pkg::GROW_STEP_DEF,
  parameter int PAYLOAD_BITS = hfl_pkg::PAYLOAD_BITS_DEF,
  localparam int HANDLE_W    = $clog2(CAPACITY + 1),
  localparam int IN_W        = HANDLE_W + PAYLOAD_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = HANDLE_W + PAYLOAD_BITS + HANDLE_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,  // handle_in, payload_in, zero pad
  input  wire [1:0]              s_axis_tuser,  // cmd
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // handle_out, payload_out, in_use_count, pad
  output logic [1:0]             m_axis_tuser   // status
);

  hfl_pkg::ctrl_cmd_t      ctrl_cmd;
  hfl_pkg::dp_status_t     dp_status;
  hfl_pkg::status_t        status;
  logic [HANDLE_W-1:0]     handle_out;
  logic [PAYLOAD_BITS-1:0] payload_out;
  logic [HANDLE_W-1:0]     in_use_count;

  hfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  hfl_dpath #(
    .CAPACITY     (CAPACITY),
    .GROW_STEP    (GROW_STEP),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl_cmd     (ctrl_cmd),
    .dp_status    (dp_status),
    .cmd_in       (hfl_pkg::cmd_t'(s_axis_tuser)),
    .handle_in    (s_axis_tdata[HANDLE_W-1:0]),
    .payload_in   (s_axis_tdata[HANDLE_W +: PAYLOAD_BITS]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .handle_out   (handle_out),
    .payload_out  (payload_out),
    .status       (status),
    .in_use_count (in_use_count)
  );

  assign m_axis_tdata = OUT_TDATA_W'({in_use_count, payload_out, handle_out});
  assign m_axis_tuser = status;

endmodule

`default_nettype wire
